>>> rtl/core/ndrange_work_item_id_generator_core_assert.svh
// Assertion macros shared by the work-item ID generator RTL.
// Each expects signals named clk and rst in the including module.
`ifndef NDRANGE_WORK_ITEM_ID_GENERATOR_CORE_ASSERT_SVH
`define NDRANGE_WORK_ITEM_ID_GENERATOR_CORE_ASSERT_SVH

// condition must hold at every edge out of reset
`define NDR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define NDR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ndr_pkg.sv
// Shared types and constants for the NDRange work-item ID generator.
// No dependencies.
`timescale 1ns / 1ps

package ndr_pkg;

  localparam int WAVE_SIZE = 64;     // power of two
  localparam int MAX_LOCAL = 1024;

  localparam int WAVE_BITS = $clog2(WAVE_SIZE);
  localparam int DIMS_W    = 2;
  localparam int GW        = 16;                      // global size / id
  localparam int LSW       = $clog2(MAX_LOCAL) + 1;   // local size register
  localparam int LW        = 10;                      // local id
  localparam int FW        = 48;                      // flat counters
  localparam int LP_W      = 3 * LSW + 1;             // unchecked local product
  localparam int WPG_W     = $clog2(MAX_LOCAL / WAVE_SIZE + 1);
  localparam int CFG_W     = 16;
  localparam int CIDX_W    = 3;
  localparam int DCNT_W    = $clog2(GW + 1);

  typedef enum logic [1:0] {
    ST_ITEM,
    ST_LAST,
    ST_INVALID,
    ST_EXHAUSTED
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DIMS,
    CFG_GSX,
    CFG_GSY,
    CFG_GSZ,
    CFG_LSX,
    CFG_LSY,
    CFG_LSZ
  } cfg_idx_t;

  typedef struct packed {
    logic           start;
    logic [GW-1:0]  dividend;
    logic [LSW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [GW-1:0]  quotient;
    logic [LSW-1:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/core/ndr_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ndr_pkg (widths and request/response structs).
`timescale 1ns / 1ps

module ndr_div
  import ndr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [DCNT_W-1:0] cnt;
  logic [GW-1:0]     quot;
  logic [LSW-1:0]    rem;
  logic [LSW-1:0]    dsr;

  logic [LSW:0]      trial;
  logic [LSW:0]      diff;
  logic              fits;

  assign trial = {rem, quot[GW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(GW);
        quot <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        // partial remainder stays below the divisor when the divisor is nonzero
        rem  <= fits ? diff[LSW-1:0] : trial[LSW-1:0];
        quot <= {quot[GW-2:0], fits};
        cnt  <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

>>> rtl/core/ndrange_work_item_id_generator_core.sv
// NDRange work-item ID generator: one work-item's IDs per word.
// Next-item request: registered the cycle after acceptance; one per cycle unless stalled.
// Restart: unless a size is zero, runs three 16-step divisions on the shared divider and
// four steps on one shared 32x16 multiplier, then emits the first item or invalid status.
// Synchronous reset: not started, counters cleared, sizes back to 1, dimensions 1.
`timescale 1ns / 1ps

module ndrange_work_item_id_generator_core
  import ndr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // request
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              restart,
  // result
  output logic              out_valid,
  input  logic              out_stall,
  output logic [GW-1:0]     global_x,
  output logic [GW-1:0]     global_y,
  output logic [GW-1:0]     global_z,
  output logic [FW-1:0]     flat_id,
  output logic [LW-1:0]     local_x,
  output logic [LW-1:0]     local_y,
  output logic [LW-1:0]     local_z,
  output logic [LW-1:0]     local_flat,
  output logic [FW-1:0]     group_number,
  output logic [FW-1:0]     wave_number,
  output logic [5:0]        lane,
  output logic [1:0]        status
);

`include "ndrange_work_item_id_generator_core_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_EMIT
  } seq_t;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_RUN,
    RS_INVALID,
    RS_DONE
  } run_t;

  // configuration registers
  logic [DIMS_W-1:0] dims;
  logic [GW-1:0]     gsize [3];
  logic [LSW-1:0]    lsize [3];

  // effective sizes and the copies latched at restart
  logic [GW-1:0]     eg [3];
  logic [LSW-1:0]    el [3];
  logic [GW-1:0]     eff_g [3];
  logic [LSW-1:0]    eff_l [3];
  logic [DIMS_W-1:0] dims_eff;
  logic              any_zero;

  // enumeration state
  seq_t              seq;
  run_t              run_state;
  logic [LW-1:0]     lc [3];
  logic [GW-1:0]     gc [3];
  logic [GW-1:0]     gcount [3];
  logic [GW-1:0]     gbase [3];
  logic [LSW-1:0]    lat [3];
  logic [FW-1:0]     flat;
  logic [FW-1:0]     gflat;
  logic [FW-1:0]     wave_base;
  logic [FW-1:0]     total;
  logic [LW-1:0]     lflat;
  logic [WPG_W-1:0]  wpg;

  // restart sequencer
  logic [1:0]        div_idx;
  logic              bad;
  logic [FW-1:0]     prod;
  logic [LP_W-1:0]   lprod;
  logic [31:0]       mul_a;
  logic [GW-1:0]     mul_b;
  logic [FW-1:0]     mul_p;
  logic [LSW:0]      wpg_sum;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // item and advance
  logic              accept;
  logic              do_emit;
  logic [GW-1:0]     item_g [3];
  logic              item_last;
  logic [FW-1:0]     item_wave;
  logic [5:0]        item_lane;
  logic [LSW-1:0]    lc_inc [3];
  logic [GW:0]       gc_inc [3];
  logic [LW-1:0]     lc_next [3];
  logic [GW-1:0]     gc_next [3];
  logic [GW-1:0]     gbase_next [3];
  logic              group_step;
  logic              lcarry;
  logic              gcarry;

  assign cfg_ready = 1'b1;
  assign in_stall  = (seq != S_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign do_emit   = (seq == S_IDLE && accept && !restart) || (seq == S_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= DIMS_W'(1);
      for (int i = 0; i < 3; i++) begin
        gsize[i] <= GW'(1);
        lsize[i] <= LSW'(1);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIMS: dims     <= cfg_data[DIMS_W-1:0];
        CFG_GSX:  gsize[0] <= cfg_data[GW-1:0];
        CFG_GSY:  gsize[1] <= cfg_data[GW-1:0];
        CFG_GSZ:  gsize[2] <= cfg_data[GW-1:0];
        CFG_LSX:  lsize[0] <= cfg_data[LSW-1:0];
        CFG_LSY:  lsize[1] <= cfg_data[LSW-1:0];
        CFG_LSZ:  lsize[2] <= cfg_data[LSW-1:0];
        default: ;
      endcase
    end
  end

  // unused dimensions count as size 1; zero dimensions means one
  always_comb begin
    dims_eff = (dims == '0) ? DIMS_W'(1) : dims;
    for (int i = 0; i < 3; i++) begin
      eff_g[i] = (DIMS_W'(i) < dims_eff) ? gsize[i] : GW'(1);
      eff_l[i] = (DIMS_W'(i) < dims_eff) ? lsize[i] : LSW'(1);
    end
  end

  assign any_zero = (eg[0] == '0) || (eg[1] == '0) || (eg[2] == '0) ||
                    (el[0] == '0) || (el[1] == '0) || (el[2] == '0);

  // shared multiplier: local product, then global product
  always_comb begin
    case (seq)
      S_MUL0: begin
        mul_a = 32'(el[0]);
        mul_b = GW'(el[1]);
      end
      S_MUL1: begin
        mul_a = prod[31:0];
        mul_b = GW'(el[2]);
      end
      S_MUL2: begin
        mul_a = 32'(eg[0]);
        mul_b = eg[1];
      end
      S_MUL3: begin
        mul_a = prod[31:0];
        mul_b = eg[2];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign wpg_sum = {1'b0, lprod[LSW-1:0]} + (LSW+1)'(WAVE_SIZE - 1);

  assign div_req.start    = (seq == S_DIV_START);
  assign div_req.dividend = eg[div_idx];
  assign div_req.divisor  = el[div_idx];

  ndr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // current item
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item_g[i] = gbase[i] + GW'(lc[i]);
    end
  end

  assign item_last = (flat + FW'(1) == total);
  assign item_wave = wave_base + FW'(lflat >> WAVE_BITS);
  assign item_lane = 6'(lflat % WAVE_SIZE);

  // odometer advance: local x,y,z then group x,y,z
  always_comb begin
    lcarry = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lc_inc[i]  = {1'b0, lc[i]} + LSW'(1);
      lc_next[i] = lc[i];
      if (lcarry) begin
        if (lc_inc[i] == lat[i]) begin
          lc_next[i] = '0;
        end else begin
          lc_next[i] = lc_inc[i][LW-1:0];
          lcarry     = 1'b0;
        end
      end
    end
    group_step = lcarry;
    gcarry     = lcarry;
    for (int i = 0; i < 3; i++) begin
      gc_inc[i]     = {1'b0, gc[i]} + (GW+1)'(1);
      gc_next[i]    = gc[i];
      gbase_next[i] = gbase[i];
      if (gcarry) begin
        if (gc_inc[i] == {1'b0, gcount[i]}) begin
          gc_next[i]    = '0;
          gbase_next[i] = '0;
        end else begin
          gc_next[i]    = gc_inc[i][GW-1:0];
          gbase_next[i] = gbase[i] + GW'(lat[i]);
          gcarry        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= S_IDLE;
      run_state <= RS_IDLE;
      out_valid <= 1'b0;
      div_idx   <= '0;
      bad       <= 1'b0;
      flat      <= '0;
      gflat     <= '0;
      wave_base <= '0;
      total     <= '0;
      lflat     <= '0;
      wpg       <= '0;
      for (int i = 0; i < 3; i++) begin
        lc[i]     <= '0;
        gc[i]     <= '0;
        gcount[i] <= '0;
        gbase[i]  <= '0;
        lat[i]    <= '0;
      end
    end else begin
      // a new word replaces the one leaving in the same cycle
      if (out_valid && !out_stall && !do_emit) begin
        out_valid <= 1'b0;
      end

      case (seq)
        S_IDLE: begin
          if (accept && restart) begin
            for (int i = 0; i < 3; i++) begin
              eg[i] <= eff_g[i];
              el[i] <= eff_l[i];
            end
            bad <= 1'b0;
            seq <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (any_zero) begin
            run_state <= RS_INVALID;
            seq       <= S_EMIT;
          end else begin
            div_idx <= '0;
            seq     <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          seq <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            gcount[div_idx] <= div_rsp.quotient;
            if (div_rsp.remainder != '0) begin
              bad <= 1'b1;
            end
            if (div_idx == 2'd2) begin
              seq <= S_MUL0;
            end else begin
              div_idx <= div_idx + 2'd1;
              seq     <= S_DIV_START;
            end
          end
        end
        S_MUL0: begin
          prod <= mul_p;
          seq  <= S_MUL1;
        end
        S_MUL1: begin
          prod <= mul_p;
          seq  <= S_MUL2;
        end
        S_MUL2: begin
          lprod <= prod[LP_W-1:0];
          prod  <= mul_p;
          seq   <= S_MUL3;
        end
        S_MUL3: begin
          prod <= mul_p;
          seq  <= S_MUL4;
        end
        S_MUL4: begin
          if (bad || (lprod > LP_W'(MAX_LOCAL))) begin
            run_state <= RS_INVALID;
          end else begin
            run_state <= RS_RUN;
            total     <= prod;
            wpg       <= WPG_W'(wpg_sum >> WAVE_BITS);
            flat      <= '0;
            gflat     <= '0;
            wave_base <= '0;
            lflat     <= '0;
            for (int i = 0; i < 3; i++) begin
              lat[i]   <= el[i];
              lc[i]    <= '0;
              gc[i]    <= '0;
              gbase[i] <= '0;
            end
          end
          seq <= S_EMIT;
        end
        S_EMIT: begin
          seq <= S_IDLE;
        end
        default: begin
          seq <= S_IDLE;
        end
      endcase

      if (do_emit) begin
        out_valid <= 1'b1;
        if (run_state == RS_RUN) begin
          global_x     <= item_g[0];
          global_y     <= item_g[1];
          global_z     <= item_g[2];
          flat_id      <= flat;
          local_x      <= lc[0];
          local_y      <= lc[1];
          local_z      <= lc[2];
          local_flat   <= lflat;
          group_number <= gflat;
          wave_number  <= item_wave;
          lane         <= item_lane;
          status       <= item_last ? ST_LAST : ST_ITEM;
          if (item_last) begin
            run_state <= RS_DONE;
          end else begin
            flat <= flat + FW'(1);
            for (int i = 0; i < 3; i++) begin
              lc[i]    <= lc_next[i];
              gc[i]    <= gc_next[i];
              gbase[i] <= gbase_next[i];
            end
            if (group_step) begin
              lflat     <= '0;
              gflat     <= gflat + FW'(1);
              wave_base <= wave_base + FW'(wpg);
            end else begin
              lflat <= lflat + LW'(1);
            end
          end
        end else begin
          global_x     <= '0;
          global_y     <= '0;
          global_z     <= '0;
          flat_id      <= '0;
          local_x      <= '0;
          local_y      <= '0;
          local_z      <= '0;
          local_flat   <= '0;
          group_number <= '0;
          wave_number  <= '0;
          lane         <= '0;
          status       <= (run_state == RS_INVALID) ? ST_INVALID : ST_EXHAUSTED;
        end
      end
    end
  end

  `NDR_ASSERT_IMPLIES(a_local_in_range, run_state == RS_RUN, (GW'(lc[0]) < GW'(lat[0])) && (GW'(lc[1]) < GW'(lat[1])) && (GW'(lc[2]) < GW'(lat[2])), "local counter beyond latched size")
  `NDR_ASSERT_IMPLIES(a_flat_below_total, run_state == RS_RUN, flat < total, "flat counter passed item count")
  `NDR_ASSERT_IMPLIES(a_last_ends_run, out_valid && status == ST_LAST, run_state == RS_DONE, "last word shown but run not closed")
  `NDR_ASSERT_IMPLIES(a_waves_set, run_state == RS_RUN, wpg != '0, "running with no waves per group")
  `NDR_ASSERT_IMPLIES(a_div_rem, div_rsp.done, GW'(div_rsp.remainder) < GW'(el[div_idx]), "divider remainder not below divisor")

endmodule

>>> test/ndrange_work_item_id_generator_core_test.sv
// Self-checking bench for the NDRange work-item ID generator core.
// Keeps its own model of the dispatch counters and checks every result word.
// Depends on ndr_pkg and ndrange_work_item_id_generator_core.
`timescale 1ns / 1ps

module ndrange_work_item_id_generator_core_test;
  import ndr_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_RUN,
    GEN_INVALID,
    GEN_DONE
  } gen_state_t;

  typedef struct packed {
    logic [2:0][GW-1:0]   gid;
    logic [FW-1:0]        flat;
    logic [2:0][LW-1:0]   lid;
    logic [LW-1:0]        lflat;
    logic [FW-1:0]        grp;
    logic [FW-1:0]        wave;
    logic [WAVE_BITS-1:0] lane;
    status_t              st;
  } id_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              restart = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [GW-1:0]     global_x, global_y, global_z;
  logic [FW-1:0]     flat_id;
  logic [LW-1:0]     local_x, local_y, local_z, local_flat;
  logic [FW-1:0]     group_number, wave_number;
  logic [5:0]        lane;
  logic [1:0]        status;

  ndrange_work_item_id_generator_core u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies as written
  logic [DIMS_W-1:0] cfg_dims = DIMS_W'(1);
  logic [GW-1:0]     cfg_gsize [3] = '{1, 1, 1};
  logic [LSW-1:0]    cfg_lsize [3] = '{1, 1, 1};

  // dispatch state, latched at restart
  gen_state_t        gen_state = GEN_IDLE;
  logic [LSW-1:0]    local_ctr [3] = '{0, 0, 0};
  logic [GW-1:0]     group_ctr [3] = '{0, 0, 0};
  logic [GW-1:0]     group_cnt [3] = '{0, 0, 0};
  logic [LSW-1:0]    lat_local [3] = '{0, 0, 0};
  logic [FW-1:0]     flat_ctr = '0;
  logic [LSW-1:0]    lflat_ctr = '0;
  logic [FW-1:0]     group_flat = '0;
  logic [FW-1:0]     wave_base = '0;
  logic [WPG_W-1:0]  waves_per_grp = '0;
  logic [FW-1:0]     total_ids = '0;

  id_word_t    pending_ids [$];
  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 0;
  bit          hold_req = 0;
  int unsigned hold_len = 0;

  function automatic id_word_t next_ids(input logic req_restart);
    id_word_t         w;
    logic [GW-1:0]    g [3];
    logic [LSW-1:0]   l [3];
    logic [LP_W-1:0]  prod;
    logic [31:0]      gpos;
    int unsigned      dims;
    logic             ok;
    logic             carry;
    w = '0;
    if (req_restart) begin
      dims = (cfg_dims == '0) ? 1 : 32'(cfg_dims);
      ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
        g[i] = (i < dims) ? cfg_gsize[i] : GW'(1);
        l[i] = (i < dims) ? cfg_lsize[i] : LSW'(1);
        if (g[i] == '0 || l[i] == '0) ok = 1'b0;
      end
      if (ok) begin
        for (int i = 0; i < 3; i++)
          if (g[i] % GW'(l[i]) != '0) ok = 1'b0;
      end
      prod = LP_W'(l[0]);
      prod = prod * LP_W'(l[1]);
      prod = prod * LP_W'(l[2]);
      if (prod > LP_W'(MAX_LOCAL)) ok = 1'b0;
      if (ok) begin
        for (int i = 0; i < 3; i++) begin
          group_cnt[i] = g[i] / GW'(l[i]);
          lat_local[i] = l[i];
          local_ctr[i] = '0;
          group_ctr[i] = '0;
        end
        total_ids = FW'(g[0]);
        total_ids = total_ids * FW'(g[1]);
        total_ids = total_ids * FW'(g[2]);
        waves_per_grp = WPG_W'((prod + LP_W'(WAVE_SIZE - 1)) >> WAVE_BITS);
        flat_ctr = '0;
        lflat_ctr = '0;
        group_flat = '0;
        wave_base = '0;
        gen_state = GEN_RUN;
      end else begin
        gen_state = GEN_INVALID;
      end
    end
    case (gen_state)
      GEN_RUN: begin
        for (int i = 0; i < 3; i++) begin
          gpos = 32'(group_ctr[i]) * 32'(lat_local[i]) + 32'(local_ctr[i]);
          w.gid[i] = gpos[GW-1:0];
          w.lid[i] = local_ctr[i][LW-1:0];
        end
        w.flat = flat_ctr;
        w.lflat = lflat_ctr[LW-1:0];
        w.grp = group_flat;
        w.wave = wave_base + FW'(lflat_ctr >> WAVE_BITS);
        w.lane = lflat_ctr[WAVE_BITS-1:0];
        if (flat_ctr + FW'(1) == total_ids) begin
          w.st = ST_LAST;
          gen_state = GEN_DONE;
        end else begin
          w.st = ST_ITEM;
          flat_ctr++;
          lflat_ctr++;
          carry = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (carry) begin
              local_ctr[i]++;
              if (local_ctr[i] < lat_local[i]) carry = 1'b0;
              else local_ctr[i] = '0;
            end
          end
          // work-group finished: step the group counters
          if (carry) begin
            lflat_ctr = '0;
            group_flat++;
            wave_base = wave_base + FW'(waves_per_grp);
            for (int i = 0; i < 3; i++) begin
              if (carry) begin
                group_ctr[i]++;
                if (group_ctr[i] < group_cnt[i]) carry = 1'b0;
                else group_ctr[i] = '0;
              end
            end
          end
        end
      end
      GEN_INVALID: w.st = ST_INVALID;
      default:     w.st = ST_EXHAUSTED;
    endcase
    return w;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 100) $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [FW-1:0] got,
                             input logic [FW-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    id_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_ids.size() == 0) begin
        flag_mismatch("result word with nothing outstanding");
      end else begin
        want = pending_ids.pop_front();
        check_field("global_x", FW'(global_x), FW'(want.gid[0]));
        check_field("global_y", FW'(global_y), FW'(want.gid[1]));
        check_field("global_z", FW'(global_z), FW'(want.gid[2]));
        check_field("flat_id", flat_id, want.flat);
        check_field("local_x", FW'(local_x), FW'(want.lid[0]));
        check_field("local_y", FW'(local_y), FW'(want.lid[1]));
        check_field("local_z", FW'(local_z), FW'(want.lid[2]));
        check_field("local_flat", FW'(local_flat), FW'(want.lflat));
        check_field("group_number", group_number, want.grp);
        check_field("wave_number", wave_number, want.wave);
        check_field("lane", FW'(lane), FW'(want.lane));
        check_field("status", FW'(status), FW'(want.st));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: mostly short stalls, some long ones, quiet stretches, and a
  // forced hold-off on request
  initial begin : receiver_stalls
    int unsigned run_left;
    int unsigned stall_left;
    run_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 0;
        run_left = 0;
        stall_left = 0;
      end else if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (run_left != 0) begin
        out_stall = 1'b0;
        run_left--;
      end else begin
        out_stall = 1'b0;
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 60)
                                                  : $urandom_range(1, 3);
      end
    end
  end

  // returns just after the accepting edge; valid stays up for a back-to-back word
  task automatic send_word(input logic req_restart);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    restart = req_restart;
    do @(posedge clk); while (in_stall);
    pending_ids.push_back(next_ids(req_restart));
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    restart = 1'b0;
    while (pending_ids.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIMS: cfg_dims = value[DIMS_W-1:0];
      CFG_GSX:  cfg_gsize[0] = value;
      CFG_GSY:  cfg_gsize[1] = value;
      CFG_GSZ:  cfg_gsize[2] = value;
      CFG_LSX:  cfg_lsize[0] = value[LSW-1:0];
      CFG_LSY:  cfg_lsize[1] = value[LSW-1:0];
      CFG_LSZ:  cfg_lsize[2] = value[LSW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] dims,
                           input logic [CFG_W-1:0] gx, gy, gz, lx, ly, lz);
    write_reg(CFG_DIMS, dims);
    write_reg(CFG_GSX, gx);
    write_reg(CFG_GSY, gy);
    write_reg(CFG_GSZ, gz);
    write_reg(CFG_LSX, lx);
    write_reg(CFG_LSY, ly);
    write_reg(CFG_LSZ, lz);
  endtask

  task automatic test_before_restart();
    send_word(1'b0);
    send_word(1'b0);
    drain();
  endtask

  task automatic test_reset_sizes();
    send_word(1'b1);
    send_word(1'b0);
    drain();
  endtask

  task automatic test_invalid_sizes();
    set_sizes(1, 8, 1, 1, 0, 1, 1);            // zero local size
    send_word(1'b1);
    drain();
    set_sizes(2, 8, 0, 1, 4, 2, 1);            // zero global size, error repeats
    send_word(1'b1);
    send_word(1'b0);
    drain();
    set_sizes(3, 12, 6, 4, 8, 3, 2);           // global not a multiple of local
    send_word(1'b1);
    drain();
    set_sizes(3, 32, 32, 16, 16, 16, 8);       // group too big
    send_word(1'b1);
    drain();
    // all data bits set: dims wraps to 3, local x to 2047
    set_sizes(16'hFFFF, 2047, 1, 1, 16'hFFFF, 1, 1);
    send_word(1'b1);
    drain();
  endtask

  task automatic test_extremes();
    set_sizes(3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1);
    send_word(1'b1);
    send_word(1'b0);
    drain();
    // zero dims counts as one; unused sizes of zero are fine
    set_sizes(0, 2048, 0, 0, 1024, 0, 0);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    drain();
    set_sizes(3, 2, 2, 1024, 1, 1, 1024);
    send_word(1'b1);
    send_word(1'b0);
    drain();
  endtask

  task automatic test_full_walk();
    // four groups of two, two along x and two along y, run past the end
    set_sizes(2, 4, 2, 9, 2, 1, 3);
    send_word(1'b1);
    repeat (8) send_word(1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    set_sizes(2, 64, 64, 1, 8, 8, 1);
    send_word(1'b1);
    drain();
    hold_len = 400;
    hold_req = 1;
    no_gaps = 1;
    repeat (60) send_word(1'b0);
    no_gaps = 0;
    drain();
  endtask

  task automatic test_random_dispatch();
    logic [DIMS_W-1:0] d;
    int unsigned       used;
    logic [GW-1:0]     g [3];
    logic [LSW-1:0]    l [3];
    longint unsigned   ids;
    int unsigned       n;
    int unsigned       k;
    int unsigned       bad;
    while (words_sent < 1450) begin
      d = DIMS_W'($urandom_range(0, 3));
      used = (d == '0) ? 1 : 32'(d);
      for (int i = 0; i < 3; i++) begin
        if (i < used) begin
          l[i] = LSW'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 1024)
                                                  : $urandom_range(1, 8));
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535 / 32'(l[i]))
                                          : $urandom_range(1, 4);
          g[i] = GW'(32'(l[i]) * k);
        end else begin
          g[i] = GW'($urandom_range(0, 65535));
          l[i] = LSW'($urandom_range(0, 2047));
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        bad = $urandom_range(0, used - 1);
        case ($urandom_range(0, 3))
          0: l[bad] = '0;
          1: g[bad] = '0;
          2: if (g[bad] != 16'hFFFF) g[bad] = g[bad] + GW'(1);
          default: l[bad] = LSW'($urandom_range(1025, 2047));
        endcase
      end
      set_sizes(CFG_W'(d), g[0], g[1], g[2], CFG_W'(l[0]), CFG_W'(l[1]), CFG_W'(l[2]));
      ids = 1;
      for (int i = 0; i < used; i++) ids = ids * 64'(g[i]);
      n = (ids <= 120 && $urandom_range(0, 2) != 0) ? 32'(ids) + $urandom_range(0, 3)
                                                    : $urandom_range(1, 60);
      no_gaps = ($urandom_range(0, 5) == 0);
      // now and then carry on the old run: new sizes must not apply yet
      send_word($urandom_range(0, 5) != 0);
      repeat (n) send_word($urandom_range(0, 29) == 0);
      no_gaps = 0;
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_before_restart();
    test_reset_sizes();
    test_invalid_sizes();
    test_extremes();
    test_full_walk();
    test_backpressure();
    test_random_dispatch();
    repeat (100) @(posedge clk);
    if (pending_ids.size() != 0) flag_mismatch("words still outstanding at the end");
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> ndrange_work_item_id_generator_core.f
+incdir+rtl/core
rtl/core/ndr_pkg.sv
rtl/core/ndr_div.sv
rtl/core/ndrange_work_item_id_generator_core.sv
test/ndrange_work_item_id_generator_core_test.sv
